@@ sv/three_channel_square_tone_generator_unit_macros.svh @@
`ifndef THREE_CHANNEL_SQUARE_TONE_GENERATOR_UNIT_MACROS_SVH
`define THREE_CHANNEL_SQUARE_TONE_GENERATOR_UNIT_MACROS_SVH

// Implication that must hold at the same edge.
`define TCSTG_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Implication that must hold at the following edge.
`define TCSTG_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tcstg_pkg.sv @@
package tcstg_pkg;

	localparam int NUM_CH    = 3;
	localparam int CH_W      = 2;
	localparam int PER_W     = 16;
	localparam int STEP_W    = 12;
	localparam int CNT_W     = 25;
	localparam int SMP_W     = 16;
	localparam int QUO_W     = 14;
	localparam int DIV_STEPS = 13;

	localparam logic              CMD_TICK   = 1'b0;
	localparam logic              CMD_WRITE  = 1'b1;
	localparam logic [CH_W-1:0]   CH_NONE    = 2'd3;
	localparam logic [STEP_W-1:0] STEP_RESET = 12'd211;

	localparam logic signed [CNT_W-1:0] CNT_MIN = 25'sh1000000;
	localparam logic signed [SMP_W-1:0] VOL_POS = 16'sd8192;
	localparam logic signed [SMP_W-1:0] VOL_NEG = -16'sd8192;
	localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sd24576;
	localparam logic signed [SMP_W-1:0] SMP_MIN = -16'sd24576;

	typedef enum logic {
		KIND_TICK,
		KIND_WRITE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CH_W-1:0]   ch;
		logic [PER_W-1:0]  period;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] dividend;
		logic [STEP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHAN,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage

@@ sv/three_channel_square_tone_generator_unit.sv @@
// Three-channel square tone generator. Push a word that either sets one channel's
// 16-bit period (command 1) or asks for one audio sample (command 0); each sample
// word yields one signed 16-bit sample on the result side, period writes yield
// nothing and a write to channel 3 is dropped. Words go through an input queue of
// QUEUE_DEPTH entries, so pushing continues while a sample waits to be popped.
// A period write is taken by the channel engine as it leaves the queue; a sample
// waits on the shared one-bit-per-cycle divider, which computes the interpolated
// edge, for each active channel that toggles from a non-negative count on that tick.
// step_size may be written at any time the block is idle; it resets to 211.
module three_channel_square_tone_generator_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               command,
	input  logic [tcstg_pkg::CH_W-1:0]         channel,
	input  logic [tcstg_pkg::PER_W-1:0]        period,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [tcstg_pkg::SMP_W-1:0] sample,
	input  logic                               step_size_we,
	input  logic [tcstg_pkg::STEP_W-1:0]       step_size
);
	import tcstg_pkg::*;

	item_t    item;
	logic     item_valid, item_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	tcstg_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.channel    (channel),
		.period     (period),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	tcstg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tcstg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size_we (step_size_we),
		.step_size    (step_size),
		.item         (item),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample)
	);

endmodule

@@ sv/tcstg_front.sv @@
module tcstg_front #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       command,
	input  logic [tcstg_pkg::CH_W-1:0] channel,
	input  logic [tcstg_pkg::PER_W-1:0] period,
	output tcstg_pkg::item_t           item,
	output logic                       item_valid,
	input  logic                       item_pop
);
	import tcstg_pkg::*;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	item_t             new_item;
	logic              accept, keep, deq;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (fill_q == FILL_W'(DEPTH));
	assign item_valid = (fill_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign accept     = push & ~full;
	// writes to the unused channel slot are taken and dropped here
	assign keep       = accept & ((command == CMD_TICK) | (channel != CH_NONE));
	assign deq        = item_pop & item_valid;

	always_comb begin
		new_item.kind   = (command == CMD_WRITE) ? KIND_WRITE : KIND_TICK;
		new_item.ch     = channel;
		new_item.period = period;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (keep)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (deq)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (keep && !deq)
				fill_q <= fill_q + 1'b1;
			else if (!keep && deq)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (keep)
			mem_q[wr_ptr_q] <= new_item;
	end

endmodule

@@ sv/tcstg_div.sv @@
module tcstg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tcstg_pkg::div_req_t req,
	output tcstg_pkg::div_rsp_t rsp
);
	import tcstg_pkg::*;

	localparam int STEPS_W = $clog2(DIV_STEPS + 1);

	logic                busy_q, done_q;
	logic [STEPS_W-1:0]  steps_q;
	logic [STEP_W-1:0]   rem_q, dvs_q;
	logic [QUO_W-1:0]    quo_q;
	logic [STEP_W:0]     rem2, rem2_sub;
	logic                ge, ge0;

	// restoring division, one quotient bit per cycle; remainder stays below divisor
	assign rem2     = {rem_q, 1'b0};
	assign ge       = (rem2 >= {1'b0, dvs_q});
	assign rem2_sub = ge ? rem2 - {1'b0, dvs_q} : rem2;
	assign ge0      = (req.dividend >= req.divisor);

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				steps_q <= STEPS_W'(DIV_STEPS);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEPS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= ge0 ? req.dividend - req.divisor : req.dividend;
			quo_q <= {{(QUO_W-1){1'b0}}, ge0};
		end else if (busy_q) begin
			rem_q <= rem2_sub[STEP_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

@@ sv/tcstg_back.sv @@
module tcstg_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_size_we,
	input  logic [tcstg_pkg::STEP_W-1:0]       step_size,
	input  tcstg_pkg::item_t                   item,
	input  logic                               item_valid,
	output logic                               item_pop,
	output tcstg_pkg::div_req_t                div_req,
	input  tcstg_pkg::div_rsp_t                div_rsp,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [tcstg_pkg::SMP_W-1:0] sample
);
	import tcstg_pkg::*;

	back_state_t state_q, state_d;

	logic [STEP_W-1:0]       step_q;
	logic [PER_W-1:0]        period_q [NUM_CH];
	logic signed [CNT_W-1:0] count_q  [NUM_CH];
	logic                    level_q  [NUM_CH];
	logic [CH_W-1:0]         ch_q;
	logic signed [SMP_W-1:0] acc_q, sample_q;
	logic                    flip_q, out_valid_q;

	logic [PER_W-1:0]        per;
	logic signed [CNT_W-1:0] prev, cnt_new;
	logic                    lvl, active, wrap, need_div, last_ch, out_free, load_out;
	logic signed [CNT_W:0]   prev_x, step_x, reload_x, diff, sum;
	logic signed [STEP_W+1:0] x, abs_x;
	logic                    neg;
	logic signed [SMP_W-1:0] fixed_contrib, quo_s, div_contrib;

	// per-channel step for the channel under work
	always_comb begin
		per      = period_q[ch_q];
		prev     = count_q[ch_q];
		lvl      = level_q[ch_q];
		active   = (per != '0);
		prev_x   = {prev[CNT_W-1], prev};
		step_x   = {{(CNT_W+1-STEP_W){1'b0}}, step_q};
		reload_x = {{(CNT_W+1-PER_W-8){1'b0}}, per, 8'b0};
		diff     = prev_x - step_x;
		wrap     = diff[CNT_W];
		sum      = wrap ? diff + reload_x : diff;
		// only the low side can leave the 25-bit range
		cnt_new  = (sum[CNT_W] != sum[CNT_W-1]) ? CNT_MIN : sum[CNT_W-1:0];
		// toggle from a non-negative count: interpolate 8192*(2*prev-step)/step
		need_div = wrap & ~prev[CNT_W-1];
		x        = $signed({1'b0, prev[STEP_W-1:0], 1'b0}) - $signed({2'b00, step_q});
		neg      = x[STEP_W+1];
		abs_x    = neg ? -x : x;
		// toggle from a negative count clamps the magnitude to -8192
		fixed_contrib = (lvl ^ wrap) ? VOL_POS : VOL_NEG;
		quo_s         = $signed({{(SMP_W-QUO_W){1'b0}}, div_rsp.quotient});
		div_contrib   = flip_q ? -quo_s : quo_s;
		last_ch       = (ch_q == CH_W'(NUM_CH - 1));
		out_free      = ~out_valid_q | pop;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && item.kind == KIND_TICK)
					state_d = ST_CHAN;
			end
			ST_CHAN: begin
				if (active && need_div)
					state_d = ST_DIV;
				else if (last_ch)
					state_d = ST_EMIT;
			end
			ST_DIV: begin
				if (div_rsp.done)
					state_d = last_ch ? ST_EMIT : ST_CHAN;
			end
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_pop         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = abs_x[STEP_W-1:0];
		div_req.divisor  = step_q;
		load_out         = 1'b0;
		case (state_q)
			ST_IDLE: item_pop      = item_valid;
			ST_CHAN: div_req.start = active & need_div;
			ST_DIV:  ;
			ST_EMIT: load_out      = out_free;
			default: ;
		endcase
	end

	assign empty  = ~out_valid_q;
	assign sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_RESET;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				period_q[i] <= '0;
				count_q[i]  <= '0;
				level_q[i]  <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (step_size_we)
				step_q <= step_size;
			if (item_pop && item.kind == KIND_WRITE)
				period_q[item.ch] <= item.period;
			if (state_q == ST_IDLE)
				ch_q <= '0;
			else if ((state_q == ST_CHAN && !(active && need_div)) ||
				 (state_q == ST_DIV && div_rsp.done))
				ch_q <= ch_q + 1'b1;
			if (state_q == ST_CHAN && active) begin
				count_q[ch_q] <= cnt_new;
				level_q[ch_q] <= lvl ^ wrap;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE)
			acc_q <= '0;
		else if (state_q == ST_CHAN && active && !need_div)
			acc_q <= acc_q + fixed_contrib;
		else if (state_q == ST_DIV && div_rsp.done)
			acc_q <= acc_q + div_contrib;
		if (div_req.start)
			flip_q <= (lvl == neg);
		if (load_out)
			sample_q <= acc_q;
	end

endmodule

@@ sv/tcstg_checker.sv @@
`include "three_channel_square_tone_generator_unit_macros.svh"

module tcstg_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic signed [tcstg_pkg::SMP_W-1:0] sample
);
	import tcstg_pkg::*;

	`TCSTG_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(sample), "result word changed before pop")
	`TCSTG_ASSERT_NOW(a_no_loss, clk, arst_n, $rose(empty), $past(pop), "result word dropped without pop")
	`TCSTG_ASSERT_NOW(a_range, clk, arst_n, !empty, sample >= SMP_MIN && sample <= SMP_MAX, "sample out of range")
	`TCSTG_ASSERT_NOW(a_reset, clk, arst_n, !$past(arst_n), empty && !full, "not idle after reset")

endmodule

bind three_channel_square_tone_generator_unit tcstg_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.sample (sample)
);

@@ tb/tone_sample_checker.sv @@
`timescale 1ns / 100ps

module tone_sample_checker
	import tcstg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic                     command,
	input  logic [CH_W-1:0]          channel,
	input  logic [PER_W-1:0]         period,
	input  logic                     empty,
	input  logic                     pop,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic                     step_size_we,
	input  logic [STEP_W-1:0]        step_size,
	output int unsigned              mismatches,
	output int unsigned              waiting,
	output int unsigned              samples_seen
);

	logic signed [CNT_W-1:0]  tone_cnt [NUM_CH];
	logic                     tone_lvl [NUM_CH];
	logic [PER_W-1:0]         tone_per [NUM_CH];
	logic [STEP_W-1:0]        step_now;
	logic signed [SMP_W-1:0]  owed_samples [$];
	logic signed [SMP_W-1:0]  want;
	int unsigned              bad;
	int unsigned              seen;

	// Advance all live channels by one tick and return the mixed sample.
	function automatic logic signed [SMP_W-1:0] mix_tick();
		longint d, prev, c, mag, sum;
		logic was;
		sum = 0;
		d = longint'(step_now);
		for (int i = 0; i < NUM_CH; i++) begin
			if (tone_per[i] != '0) begin
				prev = longint'(tone_cnt[i]);
				was = tone_lvl[i];
				c = prev - d;
				mag = longint'(VOL_POS);
				if (c < 0) begin
					c += longint'(tone_per[i]) * 256;
					tone_lvl[i] = ~was;
				end
				if (c < longint'(CNT_MIN))
					c = longint'(CNT_MIN);
				tone_cnt[i] = c[CNT_W-1:0];
				// edge inside this tick: interpolate, or clamp if counter was already negative
				if (tone_lvl[i] != was && prev < d)
					mag = (prev < 0) ? longint'(VOL_NEG)
						: (longint'(VOL_POS) * (2 * prev - d)) / d;
				sum += was ? mag : -mag;
			end
		end
		return sum[SMP_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				tone_cnt[i] = '0;
				tone_lvl[i] = 1'b0;
				tone_per[i] = '0;
			end
			step_now = STEP_RESET;
			owed_samples.delete();
			bad = 0;
			seen = 0;
		end else begin
			if (pop && !empty) begin
				if (owed_samples.size() == 0) begin
					bad++;
					$display("%0t: unexpected sample word: expected none, got %0d",
						$time, sample);
				end else begin
					want = owed_samples.pop_front();
					seen++;
					if (sample !== want) begin
						bad++;
						$display("%0t: sample mismatch: expected %0d, got %0d",
							$time, want, sample);
					end
				end
			end
			if (step_size_we)
				step_now = step_size;
			if (push && !full) begin
				if (command == CMD_TICK)
					owed_samples.push_back(mix_tick());
				else if (channel != CH_NONE)
					tone_per[channel] = period;
			end
		end
		mismatches <= bad;
		waiting <= owed_samples.size();
		samples_seen <= seen;
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import tcstg_pkg::*;

	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int     SETTLE      = 64;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic                     command = CMD_TICK;
	logic [CH_W-1:0]          channel = '0;
	logic [PER_W-1:0]         period = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [SMP_W-1:0]  sample;
	logic                     step_size_we = 1'b0;
	logic [STEP_W-1:0]        step_size = STEP_RESET;

	int unsigned mismatches, waiting, samples_seen;
	int unsigned words_pushed = 0;
	int unsigned tick_words = 0;
	int unsigned step_writes = 0;
	longint      cycle_cnt = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;
	bit          hold_go = 1'b0;
	bit          hold_now = 1'b0;

	three_channel_square_tone_generator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.channel      (channel),
		.period       (period),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample),
		.step_size_we (step_size_we),
		.step_size    (step_size)
	);

	tone_sample_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.channel      (channel),
		.period       (period),
		.empty        (empty),
		.pop          (pop),
		.sample       (sample),
		.step_size_we (step_size_we),
		.step_size    (step_size),
		.mismatches   (mismatches),
		.waiting      (waiting),
		.samples_seen (samples_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still owed", cycle_cnt, waiting);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_word(input logic cmd, input logic [CH_W-1:0] ch,
		input logic [PER_W-1:0] per);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		channel <= ch;
		period <= per;
		@(posedge clk);
		while (full) @(posedge clk);
		words_pushed++;
		if (cmd == CMD_TICK)
			tick_words++;
	endtask

	// writes can be in flight after the last sample, so give them time to retire
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] val);
		drain();
		step_size_we <= 1'b1;
		step_size <= val;
		@(posedge clk);
		step_size_we <= 1'b0;
		step_writes++;
	endtask

	task automatic random_words(input int count);
		int n, r;
		logic [CH_W-1:0] ch;
		logic [PER_W-1:0] per;
		n = 0;
		while (n < count) begin
			if (n % 50 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 28) begin
				ch = ($urandom_range(0, 9) == 0) ? CH_NONE : CH_W'($urandom_range(0, 2));
				r = $urandom_range(0, 9);
				if (r == 0)
					per = '0;
				else if (r < 5)
					per = PER_W'($urandom_range(1, 8));
				else if (r < 8)
					per = PER_W'($urandom_range(9, 80));
				else
					per = PER_W'($urandom);
				push_word(CMD_WRITE, ch, per);
				if (ch != CH_NONE)
					n++;
			end else begin
				push_word(CMD_TICK, CH_W'($urandom_range(0, 3)), PER_W'($urandom));
				n++;
			end
		end
	endtask

	// result side: random gaps per word, plus one long hold-off to back the block up
	initial begin
		int gap;
		int unsigned taken;
		taken = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			gap = rx_steady ? 0 : $urandom_range(0, 4);
			if (gap != 0 || hold_now) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_now) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			taken++;
		end
	end

	initial begin
		wait (hold_go);
		repeat (120) @(posedge clk);
		hold_now <= 1'b1;
		repeat (600) @(posedge clk);
		hold_now <= 1'b0;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: silent tick, period extremes, dropped channel, silencing
		push_word(CMD_TICK, 2'd0, 16'h0000);
		push_word(CMD_WRITE, 2'd0, 16'd1);
		push_word(CMD_WRITE, 2'd1, 16'hFFFF);
		push_word(CMD_WRITE, 2'd2, 16'd2);
		push_word(CMD_WRITE, CH_NONE, 16'hFFFF);
		repeat (7) push_word(CMD_TICK, CH_NONE, 16'hFFFF);
		push_word(CMD_WRITE, 2'd1, 16'd0);
		push_word(CMD_TICK, 2'd1, 16'h5555);
		push_word(CMD_WRITE, 2'd0, 16'hFFFF);
		push_word(CMD_WRITE, 2'd1, 16'd1);
		repeat (4) push_word(CMD_TICK, 2'd2, 16'hAAAA);
		push_word(CMD_WRITE, 2'd2, 16'd0);
		push_word(CMD_TICK, 2'd0, 16'h0000);

		hold_go = 1'b1;
		random_words(200);
		write_step(12'd1);
		random_words(200);
		write_step(12'hFFF);
		random_words(200);

		// tiny periods against the largest step: counters run far negative
		tx_steady = 1'b1;
		push_word(CMD_WRITE, 2'd0, 16'd1);
		push_word(CMD_WRITE, 2'd1, 16'd1);
		push_word(CMD_WRITE, 2'd2, 16'd2);
		repeat (700) push_word(CMD_TICK, CH_W'($urandom_range(0, 3)), PER_W'($urandom));

		// zero step with negative counters left over: toggle every tick while a count stays negative
		write_step('0);
		random_words(150);
		write_step(STEP_W'($urandom_range(1, 4095)));
		random_words(150);
		write_step(STEP_W'($urandom_range(1, 4095)));
		random_words(150);
		write_step(STEP_RESET);
		random_words(100);
		drain();

		$display("run covered %0d words (%0d sample ticks), %0d samples checked",
			words_pushed, tick_words, samples_seen);
		$display("step_size written %0d times incl. 0, 1 and 4095, plus a deep negative run",
			step_writes);
		if (mismatches == 0 && waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ three_channel_square_tone_generator_unit.f @@
+incdir+sv
sv/tcstg_pkg.sv
sv/tcstg_front.sv
sv/tcstg_div.sv
sv/tcstg_back.sv
sv/three_channel_square_tone_generator_unit.sv
sv/tcstg_checker.sv
tb/tone_sample_checker.sv
tb/tb.sv
